### hw/rtl/spd_pkg.sv
// ----------------------------------------------------------------------------
// spd_pkg: shared types and constants of the sensor packet deframer
// Frame phases, event codes, register indexes and the result item layout.
// ----------------------------------------------------------------------------
package spd_pkg;

  // Receiver capacity limit built into the frame length check
  localparam int unsigned MAX_PAYLOAD = 256;
  localparam logic [15:0] LEN_LIMIT   = 16'(MAX_PAYLOAD + 2);
  localparam logic [15:0] LEN_MIN     = 16'd2;

  // Configuration register indexes
  localparam logic [7:0] CFG_IDX_START_CODE  = 8'd0;
  localparam logic [7:0] CFG_IDX_DEVICE_ADDR = 8'd1;
  localparam logic [7:0] CFG_IDX_MAX_PAYLOAD = 8'd2;

  // Register reset values
  localparam logic [15:0] START_CODE_RST  = 16'hEF01;
  localparam logic [31:0] DEVICE_ADDR_RST = 32'hFFFF_FFFF;
  localparam logic [8:0]  MAX_PAYLOAD_RST = 9'd256;

  // Number of address bytes in a frame
  localparam logic [8:0] ADDR_BYTES = 9'd4;

  // Event codes carried on the result channel
  localparam logic [2:0] EV_BYTE   = 3'd0;
  localparam logic [2:0] EV_GOOD   = 3'd1;
  localparam logic [2:0] EV_CHKBAD = 3'd2;
  localparam logic [2:0] EV_ADDR   = 3'd3;
  localparam logic [2:0] EV_LEN    = 3'd4;

  typedef enum logic [7:0] {
    PH_HUNT  = 8'b0000_0001,
    PH_ADDR  = 8'b0000_0010,
    PH_ID    = 8'b0000_0100,
    PH_LENHI = 8'b0000_1000,
    PH_LENLO = 8'b0001_0000,
    PH_DATA  = 8'b0010_0000,
    PH_CHKHI = 8'b0100_0000,
    PH_CHKLO = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [15:0] start_code;
    logic [31:0] device_address;
    logic [8:0]  max_payload;
  } cfg_t;

  typedef struct packed {
    logic [2:0] event_kind;
    logic [7:0] value;
    logic [7:0] packet_id;
    logic [8:0] payload_length;
  } out_item_t;

endpackage

### hw/rtl/sensor_packet_deframer_top.sv
// ----------------------------------------------------------------------------
// sensor_packet_deframer_top: serial frame receiver
// Hunts for the start code, checks address, length and 16-bit checksum.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one received byte per request in in_tdata[7:0].
//   out_* : one event per request; out_tuser holds the event kind (payload
//           byte, frame good, checksum bad, address mismatch, length
//           invalid), out_tdata holds value, packet id and payload length.
//   cfg_* : register writes (start code, device address, capacity); write
//           only while the block is idle. cfg_ready is always high.
// Throughput: one byte per cycle while the result buffer is not full. Each
//   byte is registered at the input and the frame state advances from that register.
// Events: an accepted byte is first held in the input register, and its
//   event goes through the result buffer onto out_*; bytes that end
//   no field give no event.
// Stall: a two-entry result buffer absorbs a stalled receiver; in_tready
//   drops only once that buffer is full and the input register is occupied.
// Reset: rst_n low returns to hunting with a clear window, empties both
//   buffers and restores the register reset values.
// ----------------------------------------------------------------------------
module sensor_packet_deframer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] value, [15:8] packet_id, [24:16] payload_length
  output logic [2:0]  out_tuser,  // [2:0] event_kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import spd_pkg::*;

  cfg_t      cfg;
  logic      buf_ready;
  logic      push;
  out_item_t item;

  spd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  spd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .cfg_i       (cfg),
    .buf_ready_i (buf_ready),
    .push_o      (push),
    .item_o      (item)
  );

  spd_out_buf u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_i     (push),
    .item_i     (item),
    .ready_o    (buf_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

### hw/rtl/spd_cfg_regs.sv
// ----------------------------------------------------------------------------
// spd_cfg_regs: configuration register file
// Holds start code, device address and payload capacity; writes always taken.
// ----------------------------------------------------------------------------
module spd_cfg_regs (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  output spd_pkg::cfg_t cfg_o
);
  import spd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;
  assign cfg_o     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      // drop writes to unknown indexes
      case (cfg_index)
        CFG_IDX_START_CODE:  cfg_nxt.start_code     = cfg_data[15:0];
        CFG_IDX_DEVICE_ADDR: cfg_nxt.device_address = cfg_data;
        CFG_IDX_MAX_PAYLOAD: cfg_nxt.max_payload    = cfg_data[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_code     <= START_CODE_RST;
      cfg_r.device_address <= DEVICE_ADDR_RST;
      cfg_r.max_payload    <= MAX_PAYLOAD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### hw/rtl/spd_parser.sv
// ----------------------------------------------------------------------------
// spd_parser: input register and frame state machine
// Registers each received byte, then advances the frame state in one step.
// ----------------------------------------------------------------------------
module spd_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,
  input  spd_pkg::cfg_t     cfg_i,
  input  logic              buf_ready_i,
  output logic              push_o,
  output spd_pkg::out_item_t item_o
);
  import spd_pkg::*;

  logic        in_vld_r, in_vld_nxt;
  logic [7:0]  in_byte_r;
  logic        advance;

  phase_t      phase_r, phase_nxt;
  logic [15:0] window_r, window_nxt;
  logic [8:0]  count_r, count_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  chk_hi_r, chk_hi_nxt;

  logic        emit;
  out_item_t   item;

  logic [7:0]  b;
  logic [15:0] win_shift;
  logic [31:0] addr_shift;
  logic [15:0] len_full;
  logic [15:0] cap_limit;
  logic        len_bad;
  logic [15:0] chk_word;
  logic [8:0]  count_dec;

  assign advance   = in_vld_r && buf_ready_i;
  assign in_tready = !in_vld_r || buf_ready_i;
  assign b         = in_byte_r;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_tvalid && in_tready) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end
  end

  assign win_shift  = {window_r[7:0], b};
  assign addr_shift = {addr_r[23:0], b};
  assign len_full   = {len_r[15:8], b};
  assign cap_limit  = {7'd0, cfg_i.max_payload} + LEN_MIN;
  assign len_bad    = (len_full <= LEN_MIN) || (len_full > LEN_LIMIT) || (len_full > cap_limit);
  assign chk_word   = {chk_hi_r, b};
  assign count_dec  = count_r - 9'd1;

  always_comb begin
    phase_nxt  = phase_r;
    window_nxt = window_r;
    count_nxt  = count_r;
    addr_nxt   = addr_r;
    id_nxt     = id_r;
    len_nxt    = len_r;
    sum_nxt    = sum_r;
    chk_hi_nxt = chk_hi_r;
    emit       = 1'b0;
    item       = '0;
    case (phase_r)
      PH_HUNT: begin
        if (win_shift == cfg_i.start_code) begin
          window_nxt = '0;
          addr_nxt   = '0;
          count_nxt  = '0;
          phase_nxt  = PH_ADDR;
        end else begin
          window_nxt = win_shift;
        end
      end
      PH_ADDR: begin
        addr_nxt  = addr_shift;
        count_nxt = count_r + 9'd1;
        if (count_nxt == ADDR_BYTES) begin
          count_nxt = '0;
          if (addr_shift != cfg_i.device_address) begin
            phase_nxt       = PH_HUNT;
            window_nxt      = '0;
            emit            = 1'b1;
            item.event_kind = EV_ADDR;
          end else begin
            phase_nxt = PH_ID;
          end
        end
      end
      PH_ID: begin
        id_nxt    = b;
        sum_nxt   = {8'd0, b};
        phase_nxt = PH_LENHI;
      end
      PH_LENHI: begin
        len_nxt   = {b, 8'd0};
        phase_nxt = PH_LENLO;
      end
      PH_LENLO: begin
        len_nxt = len_full;
        if (len_bad) begin
          phase_nxt       = PH_HUNT;
          window_nxt      = '0;
          emit            = 1'b1;
          item.event_kind = EV_LEN;
          item.packet_id  = id_r;
        end else begin
          sum_nxt   = sum_r + {8'd0, len_full[15:8]} + {8'd0, len_full[7:0]};
          count_nxt = 9'(len_full - LEN_MIN);
          phase_nxt = (count_nxt == '0) ? PH_CHKHI : PH_DATA;
        end
      end
      PH_DATA: begin
        sum_nxt   = sum_r + {8'd0, b};
        count_nxt = count_dec;
        if (count_dec == '0) begin
          phase_nxt = PH_CHKHI;
        end
        emit            = 1'b1;
        item.event_kind = EV_BYTE;
        item.value      = b;
        item.packet_id  = id_r;
      end
      PH_CHKHI: begin
        chk_hi_nxt = b;
        phase_nxt  = PH_CHKLO;
      end
      PH_CHKLO: begin
        phase_nxt      = PH_HUNT;
        window_nxt     = '0;
        emit           = 1'b1;
        item.packet_id = id_r;
        if (chk_word != sum_r) begin
          item.event_kind = EV_CHKBAD;
        end else begin
          item.event_kind     = EV_GOOD;
          item.payload_length = 9'(len_r - LEN_MIN);
        end
      end
      default: begin
        phase_nxt  = PH_HUNT;
        window_nxt = '0;
      end
    endcase
  end

  assign push_o = advance && emit;
  assign item_o = item;

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      phase_r  <= PH_HUNT;
      window_r <= '0;
      count_r  <= '0;
      addr_r   <= '0;
      id_r     <= '0;
      len_r    <= '0;
      sum_r    <= '0;
      chk_hi_r <= '0;
    end else begin
      in_vld_r <= in_vld_nxt;
      if (advance) begin
        phase_r  <= phase_nxt;
        window_r <= window_nxt;
        count_r  <= count_nxt;
        addr_r   <= addr_nxt;
        id_r     <= id_nxt;
        len_r    <= len_nxt;
        sum_r    <= sum_nxt;
        chk_hi_r <= chk_hi_nxt;
      end
    end
  end

  // a payload byte only leaves during the data phase
  a_byte_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    push_o && (item_o.event_kind == EV_BYTE) |-> phase_r == PH_DATA)
    else $error("payload byte emitted outside data phase");

  // every rejection or frame end returns to hunting with a clear window
  a_end_hunts: assert property (@(posedge clk) disable iff (!rst_n)
    push_o && (item_o.event_kind != EV_BYTE) |=> (phase_r == PH_HUNT) && (window_r == '0))
    else $error("frame end did not return to hunting");

  // a good frame reports a payload length no larger than LEN_LIMIT
  a_good_len: assert property (@(posedge clk) disable iff (!rst_n)
    push_o && (item_o.event_kind == EV_GOOD) |-> 16'(item_o.payload_length) <= LEN_LIMIT)
    else $error("good frame length beyond capacity");

endmodule

### hw/rtl/spd_out_buf.sv
// ----------------------------------------------------------------------------
// spd_out_buf: two-entry result buffer
// Decouples the result channel stall from the input side.
// ----------------------------------------------------------------------------
module spd_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_i,
  input  spd_pkg::out_item_t item_i,
  output logic               ready_o,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [31:0]        out_tdata,
  output logic [2:0]         out_tuser
);
  import spd_pkg::*;

  out_item_t  ent0_r, ent0_nxt;
  out_item_t  ent1_r, ent1_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign pop        = (cnt_r != 2'd0) && out_tready;
  assign ready_o    = (cnt_r != 2'd2);
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tuser  = ent0_r.event_kind;
  assign out_tdata  = {7'd0, ent0_r.payload_length, ent0_r.packet_id, ent0_r.value};

  always_comb begin
    ent0_nxt = ent0_r;
    ent1_nxt = ent1_r;
    if (pop) begin
      if (cnt_r == 2'd2) begin
        ent0_nxt = ent1_r;
        if (push_i) begin
          ent1_nxt = item_i;
        end
      end else begin
        ent0_nxt = item_i;
      end
    end else if (push_i) begin
      if (cnt_r == 2'd0) begin
        ent0_nxt = item_i;
      end else begin
        ent1_nxt = item_i;
      end
    end
    cnt_nxt = cnt_r + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    ent0_r <= ent0_nxt;
    ent1_r <= ent1_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> cnt_r != 2'd2)
    else $error("result pushed into full buffer");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result buffer count out of range");

  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !push_i |=> cnt_r == $past(cnt_r) - 2'd1)
    else $error("result buffer count did not drop on pop");

endmodule
